// ===== rtl/rse_pkg.sv =====
// rse_pkg: field widths, character and status codes, and the sequencer state type
// for the rpn stack evaluator; no dependencies
`timescale 1ns / 1ps

package rse_pkg;

	localparam int CHAR_W   = 8;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2a;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_CHAR  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_LEFTOVER  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd6;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OP_B,
		S_OP_C,
		S_DIV,
		S_DIV_SGN,
		S_WB,
		S_END,
		S_FIN_RD
	} state_t;

endpackage

// ===== rtl/rse_char_if.sv =====
// rse_char_if: valid/ready channel carrying one expression character and its last flag
// depends on rse_pkg
`timescale 1ns / 1ps

interface rse_char_if;
	logic                       valid;
	logic                       ready;
	logic [rse_pkg::CHAR_W-1:0] char_code;
	logic                       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ===== rtl/rse_result_if.sv =====
// rse_result_if: valid/ready channel carrying the final value and status of an expression
// depends on rse_pkg
`timescale 1ns / 1ps

interface rse_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [rse_pkg::VALUE_W-1:0]  value;
	logic        [rse_pkg::STATUS_W-1:0] status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

// ===== rtl/rse_ram.sv =====
// rse_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/rpn_stack_evaluator.sv =====
// rpn_stack_evaluator: reverse polish evaluator over single-digit operands, stack in a ram
// depends on rse_pkg, rse_char_if, rse_result_if, rse_ram
//
//   channel  dir  payload                       transaction
//   chars    in   char_code[7:0], last_char     one expression character
//   result   out  value[31:0] signed, status[2:0]  one per expression, on last_char
//
// digit, space or bad character: accepted in S_IDLE; + - *: two stack reads, write back;
// /: radix-2 restoring divider, one quotient bit per cycle, then sign fix; skipped on zero.
// a last character that starts no operation goes through S_END; the final read adds S_FIN_RD.
// arst_n clears the sequencer, stack count and error; stack ram contents are not cleared.
// a waiting result does not block new characters; only a second result waits for the first.
`timescale 1ns / 1ps

module rpn_stack_evaluator #(
	parameter int STACK_DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	rse_char_if.sink     chars,
	rse_result_if.source result
);

	localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int VW    = rse_pkg::VALUE_W;
	localparam int DCW   = $clog2(VW);

	rse_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]             count_q;
	logic [rse_pkg::STATUS_W-1:0] err_q;
	logic                         pwd_q;
	logic                         last_q;
	rse_pkg::op_t                 op_q;
	logic                         out_valid_q;
	logic [DCW-1:0]               div_cnt_q;

	logic [VW-1:0] rhs_q, res_q, rem_q, quo_q, dvs_q;
	logic          neg_q;
	logic [VW-1:0] value_q;
	logic [rse_pkg::STATUS_W-1:0] status_q;

	// ram ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [VW-1:0] ram_wdata, ram_rdata;

	rse_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// character decode
	logic [rse_pkg::CHAR_W-1:0] ch;
	logic is_digit, is_op, is_space, is_bad, fire_in, out_free;
	logic stack_full, has_two, final_read, out_set;
	rse_pkg::op_t op_dec;
	logic [CNT_W-1:0] cnt_m1, cnt_m2;
	logic [rse_pkg::CHAR_W-1:0] digit_val;

	assign ch       = chars.char_code;
	assign is_digit = (ch >= rse_pkg::CH_ZERO) && (ch <= rse_pkg::CH_NINE);
	assign is_op    = (ch == rse_pkg::CH_PLUS) || (ch == rse_pkg::CH_MINUS) ||
	                  (ch == rse_pkg::CH_STAR) || (ch == rse_pkg::CH_SLASH);
	assign is_space = (ch == rse_pkg::CH_SPACE);
	assign is_bad   = !is_digit && !is_op && !is_space;
	assign fire_in  = chars.valid && chars.ready;
	assign out_free = !out_valid_q || result.ready;

	assign stack_full = (count_q >= CNT_W'(STACK_DEPTH));
	assign has_two    = (count_q >= CNT_W'(2));
	assign final_read = (err_q == rse_pkg::ST_OK) && (count_q == CNT_W'(1));
	assign cnt_m1     = count_q - CNT_W'(1);
	assign cnt_m2     = count_q - CNT_W'(2);
	assign digit_val  = ch - rse_pkg::CH_ZERO;

	// final entry read goes through S_FIN_RD before the result is raised
	assign out_set = ((state_q == rse_pkg::S_END) && last_q && out_free && !final_read) ||
	                 (state_q == rse_pkg::S_FIN_RD);

	always_comb begin
		case (ch)
			rse_pkg::CH_PLUS:  op_dec = rse_pkg::OP_ADD;
			rse_pkg::CH_MINUS: op_dec = rse_pkg::OP_SUB;
			rse_pkg::CH_STAR:  op_dec = rse_pkg::OP_MUL;
			default:           op_dec = rse_pkg::OP_DIV;
		endcase
	end

	// divider step and operand magnitudes
	logic [VW:0]   div_shift, div_diff;
	logic [VW-1:0] div_rem_nx, div_quo_nx;
	logic [VW-1:0] lhs_abs, rhs_abs;

	assign div_shift  = {rem_q, quo_q[VW-1]};
	assign div_diff   = div_shift - {1'b0, dvs_q};
	assign div_rem_nx = div_diff[VW] ? div_shift[VW-1:0] : div_diff[VW-1:0];
	assign div_quo_nx = {quo_q[VW-2:0], !div_diff[VW]};
	assign lhs_abs    = ram_rdata[VW-1] ? (~ram_rdata + VW'(1)) : ram_rdata;
	assign rhs_abs    = rhs_q[VW-1] ? (~rhs_q + VW'(1)) : rhs_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rse_pkg::S_IDLE: begin
				if (fire_in) begin
					if (is_op && err_q == rse_pkg::ST_OK && has_two) begin
						state_d = rse_pkg::S_OP_B;
					end else if (chars.last_char) begin
						state_d = rse_pkg::S_END;
					end
				end
			end
			rse_pkg::S_OP_B: state_d = rse_pkg::S_OP_C;
			rse_pkg::S_OP_C: begin
				if (op_q != rse_pkg::OP_DIV) begin
					state_d = rse_pkg::S_WB;
				end else if (rhs_q == '0) begin
					state_d = rse_pkg::S_END;
				end else begin
					state_d = rse_pkg::S_DIV;
				end
			end
			rse_pkg::S_DIV: begin
				if (div_cnt_q == DCW'(VW - 1)) begin
					state_d = rse_pkg::S_DIV_SGN;
				end
			end
			rse_pkg::S_DIV_SGN: state_d = rse_pkg::S_WB;
			rse_pkg::S_WB: state_d = rse_pkg::S_END;
			rse_pkg::S_END: begin
				if (!last_q) begin
					state_d = rse_pkg::S_IDLE;
				end else if (out_free) begin
					state_d = final_read ? rse_pkg::S_FIN_RD : rse_pkg::S_IDLE;
				end
			end
			rse_pkg::S_FIN_RD: state_d = rse_pkg::S_IDLE;
			default: state_d = rse_pkg::S_IDLE;
		endcase
	end

	// outputs: handshake and ram access
	always_comb begin
		chars.ready = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = count_q[AW-1:0];
		ram_wdata   = VW'(digit_val);
		ram_raddr   = cnt_m1[AW-1:0];
		unique case (state_q)
			rse_pkg::S_IDLE: begin
				chars.ready = 1'b1;
				ram_we = fire_in && is_digit && !pwd_q &&
				         (err_q == rse_pkg::ST_OK) && !stack_full;
			end
			rse_pkg::S_OP_B: ram_raddr = cnt_m2[AW-1:0];
			rse_pkg::S_WB: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_m2[AW-1:0];
				ram_wdata = res_q;
			end
			rse_pkg::S_END: ram_raddr = '0;
			default: ;
		endcase
	end

	assign result.valid  = out_valid_q;
	assign result.value  = value_q;
	assign result.status = status_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rse_pkg::S_IDLE;
			count_q     <= '0;
			err_q       <= rse_pkg::ST_OK;
			pwd_q       <= 1'b0;
			last_q      <= 1'b0;
			op_q        <= rse_pkg::OP_ADD;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				rse_pkg::S_IDLE: begin
					if (fire_in) begin
						last_q <= chars.last_char;
						op_q   <= op_dec;
						if (is_bad) begin
							err_q <= rse_pkg::ST_BAD_CHAR;
							pwd_q <= 1'b0;
						end else if (is_digit) begin
							pwd_q <= 1'b1;
							if (pwd_q) begin
								if (err_q == rse_pkg::ST_OK) err_q <= rse_pkg::ST_TOO_BIG;
							end else if (err_q == rse_pkg::ST_OK) begin
								if (stack_full) err_q <= rse_pkg::ST_OVERFLOW;
								else count_q <= count_q + CNT_W'(1);
							end
						end else begin
							pwd_q <= 1'b0;
							if (is_op && err_q == rse_pkg::ST_OK && !has_two) begin
								err_q <= rse_pkg::ST_UNDERFLOW;
							end
						end
					end
				end
				rse_pkg::S_OP_C: begin
					div_cnt_q <= '0;
					if (op_q == rse_pkg::OP_DIV && rhs_q == '0) begin
						err_q <= rse_pkg::ST_DIV_ZERO;
					end
				end
				rse_pkg::S_DIV: div_cnt_q <= div_cnt_q + DCW'(1);
				rse_pkg::S_WB: count_q <= cnt_m1;
				rse_pkg::S_END: begin
					if (last_q && out_free) begin
						count_q <= '0;
						err_q   <= rse_pkg::ST_OK;
						pwd_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			rse_pkg::S_OP_B: rhs_q <= ram_rdata;
			rse_pkg::S_OP_C: begin
				case (op_q)
					rse_pkg::OP_ADD: res_q <= ram_rdata + rhs_q;
					rse_pkg::OP_SUB: res_q <= ram_rdata - rhs_q;
					rse_pkg::OP_MUL: res_q <= ram_rdata * rhs_q;
					default: begin
						quo_q <= lhs_abs;
						dvs_q <= rhs_abs;
						rem_q <= '0;
						neg_q <= ram_rdata[VW-1] ^ rhs_q[VW-1];
					end
				endcase
			end
			rse_pkg::S_DIV: begin
				rem_q <= div_rem_nx;
				quo_q <= div_quo_nx;
			end
			rse_pkg::S_DIV_SGN: res_q <= neg_q ? (~quo_q + VW'(1)) : quo_q;
			rse_pkg::S_END: begin
				// a held result stays put until it is taken
				if (last_q && out_free) begin
					value_q  <= '0;
					status_q <= (err_q == rse_pkg::ST_OK) ? rse_pkg::ST_LEFTOVER : err_q;
				end
			end
			rse_pkg::S_FIN_RD: begin
				value_q  <= ram_rdata;
				status_q <= rse_pkg::ST_OK;
			end
			default: ;
		endcase
	end

endmodule
